### sv/vsr_pkg.sv
package vsr_pkg;

  // storage sizes
  localparam int OAM_BYTES = 256;
  localparam int OAM_AW    = $clog2(OAM_BYTES);
  localparam int PAL_BYTES = 32;
  localparam int PAL_AW    = $clog2(PAL_BYTES);

  // request types
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // register numbers
  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  // address limits of the data port
  localparam logic [15:0] VRAM_TOP    = 16'h3EFF;
  localparam logic [15:0] PALETTE_TOP = 16'h3F1F;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] reg_select;
    logic [7:0] write_data;
    logic [7:0] vram_read_data;
    logic       step_coarse_x;
    logic       step_fine_y;
    logic       reload_horizontal;
    logic       reload_vertical;
    logic       vblank_begin;
    logic       frame_prestart;
    logic       sprite_zero_hit;
    logic       sprite_overflow;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_result;
    logic [15:0] vram_access_addr;
    logic        vram_write_strobe;
    logic [7:0]  vram_write_value;
    logic        nmi_request;
    logic [15:0] scroll_address;
    logic [2:0]  fine_x_out;
    logic [7:0]  control_out;
    logic [7:0]  mask_out;
  } out_item_t;

  // sprite memory access from the core
  typedef struct packed {
    logic              wr_en;
    logic [OAM_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [OAM_AW-1:0] rd_addr;
  } oam_req_t;

endpackage

### sv/vsr_oam.sv
module vsr_oam (
  input  logic              clk,
  input  logic              rst_n,
  input  vsr_pkg::oam_req_t req,
  output logic [7:0]        rd_data
);
  import vsr_pkg::*;

  logic [7:0]           mem [OAM_BYTES];
  logic [OAM_BYTES-1:0] valid_r;
  logic [7:0]           data_rd_r;
  logic                 valid_rd_r;

  // storage and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    data_rd_r <= mem[req.rd_addr];
  end

  // written flags, an unwritten byte reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      valid_rd_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      valid_rd_r <= valid_r[req.rd_addr];
    end
  end

  assign rd_data = valid_rd_r ? data_rd_r : 8'h00;

endmodule

### sv/vsr_core.sv
module vsr_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  vsr_pkg::in_item_t  item,
  input  logic [7:0]         oam_rd_data,
  output vsr_pkg::oam_req_t  oam_req,
  output vsr_pkg::out_item_t result
);
  import vsr_pkg::*;

  logic [7:0]        ctrl_r, ctrl_nxt;
  logic [7:0]        mask_r, mask_nxt;
  logic              vbl_r, vbl_nxt;
  logic              hit_r, hit_nxt;
  logic              ovr_r, ovr_nxt;
  logic [OAM_AW-1:0] oam_addr_r, oam_addr_nxt;
  logic [15:0]       v_r, v_nxt;
  logic [15:0]       t_r, t_nxt;
  logic [2:0]        fine_x_r, fine_x_nxt;
  logic              w_r, w_nxt;
  logic [7:0]        rbuf_r, rbuf_nxt;
  logic              copy_pend_r, copy_pend_nxt;
  logic [1:0]        copy_dly_r, copy_dly_nxt;
  logic [7:0]        pal_r [PAL_BYTES];
  logic              pal_we;
  logic [PAL_AW-1:0] pal_idx;
  logic [15:0]       inc;
  logic [4:0]        y;
  logic              render;
  logic              oam_we;

  // palette index with the backdrop mirrors folded down
  always_comb begin
    pal_idx = v_r[PAL_AW-1:0];
    if (pal_idx[4] && pal_idx[1:0] == 2'b00) begin
      pal_idx[4] = 1'b0;
    end
  end

  assign inc    = ctrl_r[2] ? 16'd32 : 16'd1;
  assign render = mask_r[3] | mask_r[4];

  // one item's effect on the registers and its result
  always_comb begin
    ctrl_nxt      = ctrl_r;
    mask_nxt      = mask_r;
    vbl_nxt       = vbl_r;
    hit_nxt       = hit_r;
    ovr_nxt       = ovr_r;
    oam_addr_nxt  = oam_addr_r;
    v_nxt         = v_r;
    t_nxt         = t_r;
    fine_x_nxt    = fine_x_r;
    w_nxt         = w_r;
    rbuf_nxt      = rbuf_r;
    copy_pend_nxt = copy_pend_r;
    copy_dly_nxt  = copy_dly_r;
    pal_we        = 1'b0;
    oam_we        = 1'b0;
    y             = 5'd0;
    result        = '0;

    unique case (item.req_type)
      REQ_READ: begin
        unique case (item.reg_select)
          REG_MASK: result.read_result = mask_r;
          REG_STATUS: begin
            result.read_result = {vbl_r, hit_r, ovr_r, 5'b00000};
            vbl_nxt = 1'b0;
            w_nxt   = 1'b0;
          end
          REG_OAM_DATA: result.read_result = oam_rd_data;
          REG_DATA: begin
            result.vram_access_addr = v_r;
            if (v_r <= VRAM_TOP) begin
              result.read_result = rbuf_r;
              rbuf_nxt = item.vram_read_data;
            end else if (v_r <= PALETTE_TOP) begin
              result.read_result = pal_r[pal_idx];
              rbuf_nxt = pal_r[pal_idx];
            end else begin
              rbuf_nxt = 8'h00;
            end
            v_nxt = v_r + inc;
          end
          default: ;
        endcase
      end

      REQ_WRITE: begin
        unique case (item.reg_select)
          REG_CTRL: begin
            result.nmi_request = item.write_data[7] & ~ctrl_r[7] & vbl_r;
            ctrl_nxt = item.write_data;
            t_nxt[11:10] = item.write_data[1:0];
          end
          REG_MASK: mask_nxt = item.write_data;
          REG_OAM_ADDR: oam_addr_nxt = item.write_data[OAM_AW-1:0];
          REG_OAM_DATA: begin
            oam_we = 1'b1;
            oam_addr_nxt = oam_addr_r + OAM_AW'(1);
          end
          REG_SCROLL: begin
            if (w_r) begin
              t_nxt[14:12] = item.write_data[2:0];
              t_nxt[9:5]   = item.write_data[7:3];
            end else begin
              fine_x_nxt = item.write_data[2:0];
              t_nxt[4:0] = item.write_data[7:3];
            end
            w_nxt = ~w_r;
          end
          REG_ADDR: begin
            if (w_r) begin
              t_nxt[7:0]    = item.write_data;
              copy_pend_nxt = 1'b1;
              copy_dly_nxt  = 2'd0;
            end else begin
              t_nxt[15:8]   = {2'b00, item.write_data[5:0]};
              ctrl_nxt[1:0] = item.write_data[3:2];
            end
            w_nxt = ~w_r;
          end
          REG_DATA: begin
            result.vram_access_addr = v_r;
            if (v_r <= VRAM_TOP) begin
              result.vram_write_strobe = 1'b1;
              result.vram_write_value  = item.write_data;
            end else if (v_r <= PALETTE_TOP) begin
              pal_we = 1'b1;
            end
            v_nxt = v_r + inc;
          end
          default: ;
        endcase
      end

      REQ_TICK: begin
        if (item.sprite_zero_hit) hit_nxt = 1'b1;
        if (item.sprite_overflow) ovr_nxt = 1'b1;
        if (render) begin
          // coarse x with horizontal nametable wrap
          if (item.step_coarse_x) begin
            if (v_nxt[4:0] == 5'd31) begin
              v_nxt[4:0] = 5'd0;
              v_nxt[10]  = ~v_nxt[10];
            end else begin
              v_nxt = v_nxt + 16'd1;
            end
          end
          // fine y, then coarse y with row 29 and row 31 wrap
          if (item.step_fine_y) begin
            if (v_nxt[14:12] != 3'd7) begin
              v_nxt = v_nxt + 16'h1000;
            end else begin
              v_nxt[14:12] = 3'd0;
              y = v_nxt[9:5];
              if (y == 5'd29) begin
                y = 5'd0;
                v_nxt[11] = ~v_nxt[11];
              end else if (y == 5'd31) begin
                y = 5'd0;
              end else begin
                y = y + 5'd1;
              end
              v_nxt[9:5] = y;
            end
          end
          if (item.reload_horizontal) begin
            v_nxt[10]  = t_r[10];
            v_nxt[4:0] = t_r[4:0];
          end
          if (item.reload_vertical) begin
            v_nxt[14:11] = t_r[14:11];
            v_nxt[9:5]   = t_r[9:5];
          end
        end
        if (item.vblank_begin) begin
          vbl_nxt = 1'b1;
          result.nmi_request = ctrl_r[7];
        end
        if (item.frame_prestart) begin
          vbl_nxt = 1'b0;
          hit_nxt = 1'b0;
          ovr_nxt = 1'b0;
        end
        // delayed copy of t into v after an address write
        if (copy_pend_r) begin
          if (copy_dly_r == 2'd3) begin
            v_nxt = t_r;
            copy_pend_nxt = 1'b0;
          end else begin
            copy_dly_nxt = copy_dly_r + 2'd1;
          end
        end
      end

      default: ;
    endcase

    result.scroll_address = v_nxt;
    result.fine_x_out     = fine_x_nxt;
    result.control_out    = ctrl_nxt;
    result.mask_out       = mask_nxt;
  end

  // sprite memory port: read ahead at the address the next item will see
  always_comb begin
    oam_req.wr_en   = fire & oam_we;
    oam_req.wr_addr = oam_addr_r;
    oam_req.wr_data = item.write_data;
    oam_req.rd_addr = fire ? oam_addr_nxt : oam_addr_r;
  end

  // register state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= 8'h00;
      mask_r      <= 8'h00;
      vbl_r       <= 1'b1;
      hit_r       <= 1'b0;
      ovr_r       <= 1'b1;
      oam_addr_r  <= '0;
      v_r         <= 16'h0000;
      t_r         <= 16'h0000;
      fine_x_r    <= 3'd0;
      w_r         <= 1'b0;
      rbuf_r      <= 8'h00;
      copy_pend_r <= 1'b0;
      copy_dly_r  <= 2'd0;
    end else if (fire) begin
      ctrl_r      <= ctrl_nxt;
      mask_r      <= mask_nxt;
      vbl_r       <= vbl_nxt;
      hit_r       <= hit_nxt;
      ovr_r       <= ovr_nxt;
      oam_addr_r  <= oam_addr_nxt;
      v_r         <= v_nxt;
      t_r         <= t_nxt;
      fine_x_r    <= fine_x_nxt;
      w_r         <= w_nxt;
      rbuf_r      <= rbuf_nxt;
      copy_pend_r <= copy_pend_nxt;
      copy_dly_r  <= copy_dly_nxt;
    end
  end

  // palette bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PAL_BYTES; i++) begin
        pal_r[i] <= 8'h00;
      end
    end else if (fire && pal_we) begin
      pal_r[pal_idx] <= item.write_data;
    end
  end

endmodule

### sv/video_scroll_register_unit.sv
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | in_item  (vsr_pkg::in_item_t)
// out     | output    | out_valid / out_ready | out_item (vsr_pkg::out_item_t)
//
// one item per cycle sustained while out_ready is high; an item's result is valid once it
// has passed the input register, then the result register behind the register logic
// the sprite memory is read ahead, into a register, at the address the next item sees
// reset (rst_n low at a clock edge) empties both stages and restores the registers
// a stalled result holds the result register; the input register keeps filling
// until both stages hold an item
module video_scroll_register_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  vsr_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output vsr_pkg::out_item_t out_item
);
  import vsr_pkg::*;

  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;
  out_item_t result;
  oam_req_t  oam_req;
  logic [7:0] oam_rd_data;
  logic      fire;

  // item moves from the input register into the result register
  assign fire     = in_vld_r & (~out_vld_r | out_ready);
  assign in_ready = ~in_vld_r | fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  vsr_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .item        (in_item_r),
    .oam_rd_data (oam_rd_data),
    .oam_req     (oam_req),
    .result      (result)
  );

  vsr_oam u_oam (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (oam_req),
    .rd_data (oam_rd_data)
  );

endmodule

### sv/vsr_checker.sv
module vsr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input vsr_pkg::out_item_t out_item
);
  import vsr_pkg::*;

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // input back-pressure only comes from a stalled result
  a_in_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  // external writes only below the palette range, and never with read data
  a_strobe_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.vram_write_strobe |->
      out_item.vram_access_addr <= VRAM_TOP && out_item.read_result == 8'h00)
    else $error("write strobe outside external memory range");

endmodule

bind video_scroll_register_unit vsr_checker u_vsr_checker (.*);
